// ----- rtl/drc_pkg.sv -----
// Package for the download response checker: result codes, CRC constants,
// the result bundle and the status byte mapping.
// No dependencies.
package drc_pkg;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [CountW-1:0] MIN_FRAME_BYTES = 17'd5;
  localparam logic [CountW-1:0] FRAME_OVERHEAD = 17'd4;

  localparam logic [7:0] STATUS_OK = 8'h00;
  localparam logic [7:0] STATUS_BUSY = 8'h20;
  localparam logic [7:0] STATUS_KEY = 8'h21;
  localparam logic [7:0] STATUS_ALREADY = 8'h24;
  localparam logic [7:0] STATUS_PROGRESS_A = 8'h2D;
  localparam logic [7:0] STATUS_PROGRESS_B = 8'h2E;

  typedef enum logic [2:0] {
    RC_OK       = 3'd0,
    RC_PROTOCOL = 3'd1,
    RC_CRC      = 3'd2,
    RC_BUSY     = 3'd3,
    RC_KEY      = 3'd4,
    RC_ALREADY  = 3'd5,
    RC_PROGRESS = 3'd6,
    RC_REMOTE   = 3'd7
  } result_code_e;

  typedef struct packed {
    result_code_e code;
    logic [7:0]   status;
    logic [15:0]  length;
  } drc_result_t;

  function automatic result_code_e map_status(input logic [7:0] s);
    result_code_e rc;
    case (s)
      STATUS_OK:                            rc = RC_OK;
      STATUS_BUSY:                          rc = RC_BUSY;
      STATUS_KEY:                           rc = RC_KEY;
      STATUS_ALREADY:                       rc = RC_ALREADY;
      STATUS_PROGRESS_A, STATUS_PROGRESS_B: rc = RC_PROGRESS;
      default:                              rc = RC_REMOTE;
    endcase
    return rc;
  endfunction

endpackage

// ----- rtl/drc_crc16_step.sv -----
// One-byte CRC-16 update, polynomial 0x1021, MSB first, unrolled.
// Depends on drc_pkg.
module drc_crc16_step
  import drc_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  logic [15:0] c;

  always_comb begin
    c = crc_i ^ {byte_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
  end

  assign crc_o = c;

endmodule

// ----- rtl/drc_frame_state.sv -----
// Frame tracking state: byte count, length field, CRC, check delay line
// and first payload byte, plus the end-of-frame decision.
// Depends on drc_pkg and drc_crc16_step.
module drc_frame_state
  import drc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output drc_result_t result_o
);

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [15:0] len_q, len_d;
  logic [15:0] crc_q, crc_d, crc_next;
  logic [15:0] chk_q, chk_d;
  logic [7:0]  fpb_q, fpb_d;
  logic        proto_err;

  drc_crc16_step u_crc (
    .crc_i  (crc_q),
    .byte_i (chk_q[15:8]),
    .crc_o  (crc_next)
  );

  always_comb begin
    len_d = len_q;
    fpb_d = fpb_q;
    if (cnt_q == '0) begin
      len_d = {byte_i, 8'h00};
    end else if (cnt_q == CountW'(1)) begin
      len_d = {len_q[15:8], byte_i};
    end else if (cnt_q == CountW'(2)) begin
      fpb_d = byte_i;
    end
    crc_d = (cnt_q >= CountW'(2)) ? crc_next : crc_q;
    chk_d = {chk_q[7:0], byte_i};
    cnt_d = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + CountW'(1);
  end

  // Decide on the updated state, counting the last byte.
  always_comb begin
    proto_err = (cnt_d < MIN_FRAME_BYTES) || (len_d == '0) ||
                (cnt_d != ({1'b0, len_d} + FRAME_OVERHEAD));
    if (proto_err) begin
      result_o.code = RC_PROTOCOL;
    end else if (crc_d != chk_d) begin
      result_o.code = RC_CRC;
    end else begin
      result_o.code = map_status(fpb_d);
    end
    result_o.status = fpb_d;
    result_o.length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      len_q <= '0;
      crc_q <= CRC_INIT;
      chk_q <= '0;
      fpb_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        cnt_q <= '0;
        len_q <= '0;
        crc_q <= CRC_INIT;
        chk_q <= '0;
        fpb_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        len_q <= len_d;
        crc_q <= crc_d;
        chk_q <= chk_d;
        fpb_q <= fpb_d;
      end
    end
  end

  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> cnt_q == '0 && crc_q == CRC_INIT && chk_q == '0)
    else $error("frame state not cleared after last byte");

  a_short_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i && cnt_q < CountW'(4) |-> result_o.code == RC_PROTOCOL)
    else $error("short frame not flagged as protocol error");

  a_count_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !last_i && cnt_q == COUNT_MAX |=> cnt_q == COUNT_MAX)
    else $error("byte count wrapped");

endmodule

// ----- rtl/download_response_checker_core.sv -----
// Download response checker: one byte per item, one result per frame.
// Path: an accepted closing byte passes the input register, then the result
// register, where the result is held until taken.
// Throughput: one byte per cycle, set by the unrolled combinational CRC update;
// a closing byte waits only while an earlier result is still untaken.
// Reset clears all frame state (CRC back to 0xFFFF) and empties both registers.
module download_response_checker_core
  import drc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_code_o,
  output logic [7:0]  status_byte_o,
  output logic [15:0] payload_length_o
);

  // Input register: holds the accepted byte until the frame logic takes it.
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       last_q;

  // Result register: holds the end-of-frame result until taken.
  logic        out_valid_q, out_valid_d;
  drc_result_t res_q;
  drc_result_t res_comb;

  logic advance;
  logic load_in;

  // Advance a byte unless it closes a frame while the result register is
  // still full and not being drained this cycle. Non-last bytes never stall.
  assign advance = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign load_in = in_valid_i && in_ready_o;

  drc_frame_state u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (byte_q),
    .last_i   (last_q),
    .result_o (res_comb)
  );

  always_comb begin
    in_valid_d = in_ready_o ? in_valid_i : in_valid_q;
    if (advance && last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: capture on load or on a closing byte, no reset needed.
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (advance && last_q) begin
      res_q <= res_comb;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_code_o    = 3'(res_q.code);
  assign status_byte_o    = res_q.status;
  assign payload_length_o = res_q.length;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q && out_valid_q |-> out_ready_i)
    else $error("pending result overwritten");

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input stalled with empty input register");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q ##1 out_valid_q |-> $past(advance && last_q))
    else $error("result appeared without a closing byte");

endmodule
